/* design/assert_macros.svh */
// Assertion macros shared by the supervisor RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Implication or plain property, checked on every rising clock edge out of reset
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Expression that must never be true out of reset
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

/* design/lsrs_pkg.sv */
// Types and codes shared by the link silence and reconnect supervisor
package lsrs_pkg;

   // Supervisor phase, one-hot
   typedef enum logic [2:0] {
      PHASE_STARTING = 3'b001,
      PHASE_RUNNING  = 3'b010,
      PHASE_FINISHED = 3'b100
   } phase_type;

   // Item kinds
   localparam logic FUNC_POLL  = 1'b0;
   localparam logic FUNC_START = 1'b1;

   localparam logic [2:0] POLL_SAMPLES   = 3'd0;
   localparam logic [2:0] POLL_EMPTY     = 3'd1;
   localparam logic [2:0] POLL_NO_ANSWER = 3'd2;
   localparam logic [2:0] POLL_BAD_RESP  = 3'd3;
   localparam logic [2:0] POLL_OTHER_ERR = 3'd4;
   localparam logic [2:0] POLL_CANCELLED = 3'd5;

   localparam logic [1:0] START_SUCCESS  = 2'd0;
   localparam logic [1:0] START_BAD_RESP = 2'd1;

   localparam logic [1:0] FINISH_NONE      = 2'd0;
   localparam logic [1:0] FINISH_CANCELLED = 2'd1;
   localparam logic [1:0] FINISH_ERROR     = 2'd2;
   localparam logic [1:0] FINISH_EXHAUSTED = 2'd3;

   // Register map
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 32;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MISS_THRESHOLD    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FIRST_RETRY_DELAY = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RETRY_PERIOD      = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ATTEMPT_LIMIT_ON  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ATTEMPT_LIMIT     = 3'd4;

   localparam logic [15:0] MISS_COUNT_MAX    = 16'hFFFF;
   localparam logic [31:0] ATTEMPT_COUNT_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [15:0] miss_threshold;
      logic [31:0] first_retry_delay;
      logic [31:0] retry_period;
      logic        attempt_limit_on;
      logic [31:0] attempt_limit;
   } cfg_type;

   typedef struct packed {
      logic       func;
      logic [2:0] poll_kind;
      logic [1:0] start_kind;
   } item_type;

   typedef struct packed {
      logic       report_running;
      logic       report_silent;
      logic       forward_samples;
      logic       request_restart;
      logic       finish;
      logic [1:0] finish_code;
      logic       log_retry_failure;
   } result_type;

   typedef struct packed {
      phase_type phase;
      logic      awaiting_restart;
   } status_type;

endpackage

/* design/lsrs_csr.sv */
// Configuration registers of the supervisor
module lsrs_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [lsrs_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [lsrs_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata,
   output lsrs_pkg::cfg_type                      cfg
);

   lsrs_pkg::cfg_type cfg_ff;
   lsrs_pkg::cfg_type cfg_in;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            lsrs_pkg::CSR_MISS_THRESHOLD:    cfg_in.miss_threshold    = csr_wdata[15:0];
            lsrs_pkg::CSR_FIRST_RETRY_DELAY: cfg_in.first_retry_delay = csr_wdata;
            lsrs_pkg::CSR_RETRY_PERIOD:      cfg_in.retry_period      = csr_wdata;
            lsrs_pkg::CSR_ATTEMPT_LIMIT_ON:  cfg_in.attempt_limit_on  = csr_wdata[0];
            lsrs_pkg::CSR_ATTEMPT_LIMIT:     cfg_in.attempt_limit     = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // Hold the settings
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.miss_threshold    <= 16'd3;
         cfg_ff.first_retry_delay <= 32'd1000;
         cfg_ff.retry_period      <= 32'd1000;
         cfg_ff.attempt_limit_on  <= 1'b0;
         cfg_ff.attempt_limit     <= 32'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* design/lsrs_in_reg.sv */
// Input register stage of the supervisor
module lsrs_in_reg #(
   parameter int unsigned TIME_WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  lsrs_pkg::item_type       req_item,
   input  logic [63:0]              req_now_ms,
   input  logic                     advance,
   output logic                     item_valid,
   output lsrs_pkg::item_type       item,
   output logic [TIME_WIDTH-1:0]    item_now
);

   logic                  valid_ff;
   logic                  valid_in;
   lsrs_pkg::item_type    item_ff;
   logic [TIME_WIDTH-1:0] now_ff;
   logic                  take;

   // Take a beat whenever the stage is empty or drains this cycle
   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture the payload, keeping only the time bits in use
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_item;
         now_ff  <= req_now_ms[TIME_WIDTH-1:0];
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;
   assign item_now   = now_ff;

endmodule

/* design/lsrs_step.sv */
// Supervisor state and the single-pass update for one item
module lsrs_step #(
   parameter int unsigned TIME_WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  lsrs_pkg::cfg_type        cfg,
   input  logic                     advance,
   input  lsrs_pkg::item_type       item,
   input  logic [TIME_WIDTH-1:0]    item_now,
   output lsrs_pkg::result_type     result,
   output lsrs_pkg::status_type     status
);

   localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

   lsrs_pkg::phase_type   phase_ff, phase_in;
   logic                  silent_ff, silent_in;
   logic [15:0]           miss_ff, miss_in;
   logic [31:0]           attempt_ff, attempt_in;
   logic [TIME_WIDTH-1:0] deadline_ff, deadline_in;
   logic                  armed_ff, armed_in;
   logic                  reachable_ff, reachable_in;
   logic                  awaiting_ff, awaiting_in;
   logic                  retry_failed_ff, retry_failed_in;

   logic [31:0]           arm_delta;
   logic [TIME_WIDTH:0]   arm_sum;
   logic [TIME_WIDTH-1:0] arm_time;
   logic                  arm_reachable;
   logic [15:0]           miss_next;
   logic                  old_deadline_hit;
   logic                  new_deadline_hit;
   logic                  limit_hit;
   lsrs_pkg::result_type  res;

   // Deadline arithmetic: one adder, saturate on carry out
   assign arm_delta     = (item.func == lsrs_pkg::FUNC_START) ? cfg.retry_period
                                                              : cfg.first_retry_delay;
   assign arm_sum       = {1'b0, item_now} + {{(TIME_WIDTH - 31){1'b0}}, arm_delta};
   assign arm_reachable = !arm_sum[TIME_WIDTH];
   assign arm_time      = arm_reachable ? arm_sum[TIME_WIDTH-1:0] : TIME_MAX;

   // A freshly armed deadline has passed only when its delay is zero
   assign old_deadline_hit = armed_ff && reachable_ff && (item_now >= deadline_ff);
   assign new_deadline_hit = arm_reachable && (arm_delta == 32'd0);
   assign limit_hit        = cfg.attempt_limit_on && (attempt_ff >= cfg.attempt_limit);
   assign miss_next        = miss_ff + 16'd1;

   always_comb begin
      phase_in        = phase_ff;
      silent_in       = silent_ff;
      miss_in         = miss_ff;
      attempt_in      = attempt_ff;
      deadline_in     = deadline_ff;
      armed_in        = armed_ff;
      reachable_in    = reachable_ff;
      awaiting_in     = awaiting_ff;
      retry_failed_in = retry_failed_ff;
      res             = '0;

      unique case (phase_ff)
         lsrs_pkg::PHASE_STARTING: begin
            if (item.func == lsrs_pkg::FUNC_START) begin
               if (item.start_kind == lsrs_pkg::START_SUCCESS) begin
                  phase_in           = lsrs_pkg::PHASE_RUNNING;
                  res.report_running = 1'b1;
               end else begin
                  phase_in        = lsrs_pkg::PHASE_FINISHED;
                  res.finish      = 1'b1;
                  res.finish_code = lsrs_pkg::FINISH_ERROR;
               end
            end else if (item.poll_kind == lsrs_pkg::POLL_CANCELLED) begin
               phase_in        = lsrs_pkg::PHASE_FINISHED;
               res.finish      = 1'b1;
               res.finish_code = lsrs_pkg::FINISH_CANCELLED;
            end
         end

         lsrs_pkg::PHASE_RUNNING: begin
            if (item.func == lsrs_pkg::FUNC_START) begin
               // Restart outcome: count the attempt and re-arm
               if (awaiting_ff) begin
                  awaiting_in  = 1'b0;
                  if (attempt_ff != lsrs_pkg::ATTEMPT_COUNT_MAX) begin
                     attempt_in = attempt_ff + 32'd1;
                  end
                  armed_in     = 1'b1;
                  deadline_in  = arm_time;
                  reachable_in = arm_reachable;
                  if (item.start_kind == lsrs_pkg::START_BAD_RESP) begin
                     retry_failed_in = 1'b1;
                  end else if (item.start_kind != lsrs_pkg::START_SUCCESS) begin
                     phase_in        = lsrs_pkg::PHASE_FINISHED;
                     res.finish      = 1'b1;
                     res.finish_code = lsrs_pkg::FINISH_ERROR;
                  end
               end
            end else if (!awaiting_ff) begin
               case (item.poll_kind)
                  lsrs_pkg::POLL_SAMPLES: begin
                     miss_in             = '0;
                     attempt_in          = '0;
                     armed_in            = 1'b0;
                     reachable_in        = 1'b0;
                     deadline_in         = '0;
                     retry_failed_in     = 1'b0;
                     silent_in           = 1'b0;
                     res.report_running  = silent_ff;
                     res.forward_samples = 1'b1;
                  end
                  lsrs_pkg::POLL_OTHER_ERR,
                  lsrs_pkg::POLL_CANCELLED: begin
                     phase_in        = lsrs_pkg::PHASE_FINISHED;
                     res.finish      = 1'b1;
                     res.finish_code = (item.poll_kind == lsrs_pkg::POLL_CANCELLED)
                                     ? lsrs_pkg::FINISH_CANCELLED
                                     : lsrs_pkg::FINISH_ERROR;
                  end
                  lsrs_pkg::POLL_NO_ANSWER: begin
                     if ((miss_ff != lsrs_pkg::MISS_COUNT_MAX)
                         && (miss_next == cfg.miss_threshold)) begin
                        // Silence declared: arm the first deadline
                        silent_in         = 1'b1;
                        res.report_silent = 1'b1;
                        armed_in          = 1'b1;
                        deadline_in       = arm_time;
                        reachable_in      = arm_reachable;
                        if (new_deadline_hit) begin
                           if (limit_hit) begin
                              phase_in              = lsrs_pkg::PHASE_FINISHED;
                              res.finish            = 1'b1;
                              res.finish_code       = lsrs_pkg::FINISH_EXHAUSTED;
                              res.log_retry_failure = retry_failed_ff;
                           end else begin
                              awaiting_in         = 1'b1;
                              res.request_restart = 1'b1;
                           end
                        end
                     end else if (old_deadline_hit) begin
                        if (limit_hit) begin
                           phase_in              = lsrs_pkg::PHASE_FINISHED;
                           res.finish            = 1'b1;
                           res.finish_code       = lsrs_pkg::FINISH_EXHAUSTED;
                           res.log_retry_failure = retry_failed_ff;
                        end else begin
                           awaiting_in         = 1'b1;
                           res.request_restart = 1'b1;
                        end
                     end
                     if (miss_ff != lsrs_pkg::MISS_COUNT_MAX) begin
                        miss_in = miss_next;
                     end
                  end
                  default: begin
                     // Empty answers, bad responses and unused codes change nothing
                     miss_in = miss_ff;
                  end
               endcase
            end
         end

         lsrs_pkg::PHASE_FINISHED: begin
            phase_in = lsrs_pkg::PHASE_FINISHED;
         end

         default: begin
            phase_in = lsrs_pkg::PHASE_FINISHED;
         end
      endcase
   end

   // Commit the state as the item leaves the input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= lsrs_pkg::PHASE_STARTING;
         silent_ff       <= 1'b0;
         miss_ff         <= '0;
         attempt_ff      <= '0;
         deadline_ff     <= '0;
         armed_ff        <= 1'b0;
         reachable_ff    <= 1'b0;
         awaiting_ff     <= 1'b0;
         retry_failed_ff <= 1'b0;
      end else if (advance) begin
         phase_ff        <= phase_in;
         silent_ff       <= silent_in;
         miss_ff         <= miss_in;
         attempt_ff      <= attempt_in;
         deadline_ff     <= deadline_in;
         armed_ff        <= armed_in;
         reachable_ff    <= reachable_in;
         awaiting_ff     <= awaiting_in;
         retry_failed_ff <= retry_failed_in;
      end
   end

   assign result                  = res;
   assign status.phase            = phase_ff;
   assign status.awaiting_restart = awaiting_ff;

endmodule

/* design/lsrs_out_reg.sv */
// Result register of the supervisor
module lsrs_out_reg (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  lsrs_pkg::result_type    result,
   output logic                    out_free,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output lsrs_pkg::result_type    rsp_result
);

   logic                 valid_ff;
   logic                 valid_in;
   lsrs_pkg::result_type result_ff;

   // The register can take a beat when empty or being emptied now
   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

/* design/link_silence_reconnect_supervisor.sv */
// Top level of the link silence and reconnect supervisor
//
//   channel   direction   handshake                    payload
//   req_      in          req_valid / req_ready        func, poll_kind, start_kind, now_ms
//   rsp_      out         rsp_valid / rsp_ready        seven result fields
//   csr_      in          csr_we (no wait)             csr_index, csr_wdata
//
// An accepted beat sits in the input register while the update logic works on
// it; its result is then loaded into the result register and offered from
// there, so a result beat passes through both registers before it is taken.
// While results are taken, a new beat is accepted every cycle; the state update
// commits as an item moves into the result register, so the next item sees it.
// A stalled result register holds the input stage, and the input stage takes
// a new beat in the same cycle that it drains. Reset is synchronous and empties
// both registers.
`include "assert_macros.svh"

module link_silence_reconnect_supervisor #(
   parameter int unsigned TIME_WIDTH = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_func,
   input  logic [2:0]                             req_poll_kind,
   input  logic [1:0]                             req_start_kind,
   input  logic [63:0]                            req_now_ms,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_report_running,
   output logic                                   rsp_report_silent,
   output logic                                   rsp_forward_samples,
   output logic                                   rsp_request_restart,
   output logic                                   rsp_finish,
   output logic [1:0]                             rsp_finish_code,
   output logic                                   rsp_log_retry_failure,
   input  logic                                   csr_we,
   input  logic [lsrs_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [lsrs_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   lsrs_pkg::cfg_type     cfg;
   lsrs_pkg::item_type    req_item;
   lsrs_pkg::item_type    item;
   logic [TIME_WIDTH-1:0] item_now;
   logic                  item_valid;
   logic                  out_free;
   logic                  advance;
   lsrs_pkg::result_type  result;
   lsrs_pkg::result_type  rsp_result;
   lsrs_pkg::status_type  status;

   assign req_item.func       = req_func;
   assign req_item.poll_kind  = req_poll_kind;
   assign req_item.start_kind = req_start_kind;

   // Move an item on when the result register can take it
   assign advance = item_valid && out_free;

   lsrs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lsrs_in_reg #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .req_now_ms (req_now_ms),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item),
      .item_now   (item_now)
   );

   lsrs_step #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_step (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .advance  (advance),
      .item     (item),
      .item_now (item_now),
      .result   (result),
      .status   (status)
   );

   lsrs_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result     (result),
      .out_free   (out_free),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (rsp_result)
   );

   assign rsp_report_running    = rsp_result.report_running;
   assign rsp_report_silent     = rsp_result.report_silent;
   assign rsp_forward_samples   = rsp_result.forward_samples;
   assign rsp_request_restart   = rsp_result.request_restart;
   assign rsp_finish            = rsp_result.finish;
   assign rsp_finish_code       = rsp_result.finish_code;
   assign rsp_log_retry_failure = rsp_result.log_retry_failure;

   // A finish code goes with a finish and nothing else
   `ASSERT_PROP(a_code_with_finish, clock, reset,
      rsp_valid |-> (rsp_finish == (rsp_finish_code != lsrs_pkg::FINISH_NONE)))
   // The retry-failure log only rides on an exhausted finish
   `ASSERT_PROP(a_log_only_exhausted, clock, reset,
      (rsp_valid && rsp_log_retry_failure) |->
         (rsp_finish_code == lsrs_pkg::FINISH_EXHAUSTED))
   // Once finished the supervisor never leaves that phase
   `ASSERT_PROP(a_finished_sticks, clock, reset,
      (status.phase == lsrs_pkg::PHASE_FINISHED) |=>
         (status.phase == lsrs_pkg::PHASE_FINISHED))
   // A restart is awaited only while running
   `ASSERT_NEVER(a_await_only_running, clock, reset,
      status.awaiting_restart && (status.phase != lsrs_pkg::PHASE_RUNNING))

endmodule

/* dv/link_silence_reconnect_supervisor_tb.sv */
// Self-checking testbench for the link silence and reconnect supervisor
module link_silence_reconnect_supervisor_tb;

   localparam int          QUIET_LIMIT     = 2000;
   localparam int          HOLD_OFF_CYCLES = 120;
   localparam int          RANDOM_BEATS    = 120;
   localparam logic [63:0] TIME_MAX        = '1;
   localparam logic [2:0]  POLL_UNUSED_LO  = 3'd6;
   localparam logic [2:0]  POLL_UNUSED_HI  = 3'd7;
   localparam logic [1:0]  START_OTHER_ERR = 2'd2;
   localparam logic [1:0]  START_UNUSED    = 2'd3;

   typedef struct {
      logic       func;
      logic [2:0] poll_kind;
      logic [1:0] start_kind;
      logic [63:0] now_ms;
   } link_beat_type;

   typedef struct {
      lsrs_pkg::phase_type phase;
      logic                silent_reported;
      logic [15:0]         miss_count;
      logic [31:0]         attempt_count;
      logic [63:0]         deadline;
      logic                armed;
      logic                reachable;
      logic                awaiting;
      logic                retry_failed;
   } link_state_type;

   typedef enum {SINK_EAGER, SINK_BUSY, SINK_CHOKED} sink_mode_type;
   typedef enum {END_CANCEL, END_POLL_ERROR, END_RESTART_ERROR, END_EXHAUSTED}
      session_end_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_func = 1'b0;
   logic [2:0]  req_poll_kind = '0;
   logic [1:0]  req_start_kind = '0;
   logic [63:0] req_now_ms = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_report_running;
   logic        rsp_report_silent;
   logic        rsp_forward_samples;
   logic        rsp_request_restart;
   logic        rsp_finish;
   logic [1:0]  rsp_finish_code;
   logic        rsp_log_retry_failure;
   logic        csr_we = 1'b0;
   logic [lsrs_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [lsrs_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   link_state_type       link_model;
   lsrs_pkg::cfg_type    cfg_model;
   lsrs_pkg::result_type expected_outcomes[$];
   logic [63:0] wall_ms = 64'd1000;
   int          burst_left = 0;
   bit          hold_off_request = 1'b0;
   int          quiet_cycles = 0;
   int          mismatches = 0;
   int          beats_sent = 0;
   int          results_checked = 0;
   int          settings_programmed = 0;
   int          silences_seen = 0;
   int          restarts_seen = 0;
   string       session_ending = "nothing";

   link_silence_reconnect_supervisor u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_func              (req_func),
      .req_poll_kind         (req_poll_kind),
      .req_start_kind        (req_start_kind),
      .req_now_ms            (req_now_ms),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_report_running    (rsp_report_running),
      .rsp_report_silent     (rsp_report_silent),
      .rsp_forward_samples   (rsp_forward_samples),
      .rsp_request_restart   (rsp_request_restart),
      .rsp_finish            (rsp_finish),
      .rsp_finish_code       (rsp_finish_code),
      .rsp_log_retry_failure (rsp_log_retry_failure),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   // Arm the reconnect deadline; an overflowing sum pins it at the top, never to fire
   function automatic void arm_deadline(inout link_state_type st, input logic [63:0] base,
                                        input logic [31:0] delay);
      st.armed = 1'b1;
      if (64'(delay) > ~base) begin
         st.deadline  = TIME_MAX;
         st.reachable = 1'b0;
      end else begin
         st.deadline  = base + 64'(delay);
         st.reachable = 1'b1;
      end
   endfunction

   function automatic void end_session(inout link_state_type st,
                                       inout lsrs_pkg::result_type r,
                                       input logic [1:0] code);
      st.phase      = lsrs_pkg::PHASE_FINISHED;
      r.finish      = 1'b1;
      r.finish_code = code;
   endfunction

   // Advance the supervisor state by one beat and return the result it owes
   function automatic lsrs_pkg::result_type supervise(input link_beat_type b,
                                                      inout link_state_type st,
                                                      input lsrs_pkg::cfg_type c);
      lsrs_pkg::result_type r;
      r = '0;
      case (st.phase)
         lsrs_pkg::PHASE_STARTING: begin
            if (b.func == lsrs_pkg::FUNC_START) begin
               if (b.start_kind == lsrs_pkg::START_SUCCESS) begin
                  st.phase         = lsrs_pkg::PHASE_RUNNING;
                  r.report_running = 1'b1;
               end else begin
                  end_session(st, r, lsrs_pkg::FINISH_ERROR);
               end
            end else if (b.poll_kind == lsrs_pkg::POLL_CANCELLED) begin
               end_session(st, r, lsrs_pkg::FINISH_CANCELLED);
            end
         end
         lsrs_pkg::PHASE_RUNNING: begin
            if (b.func == lsrs_pkg::FUNC_START) begin
               // a start outcome only counts when a restart was requested
               if (st.awaiting) begin
                  st.awaiting = 1'b0;
                  if (st.attempt_count != lsrs_pkg::ATTEMPT_COUNT_MAX) st.attempt_count++;
                  arm_deadline(st, b.now_ms, c.retry_period);
                  if (b.start_kind == lsrs_pkg::START_BAD_RESP) st.retry_failed = 1'b1;
                  else if (b.start_kind != lsrs_pkg::START_SUCCESS)
                     end_session(st, r, lsrs_pkg::FINISH_ERROR);
               end
            end else if (!st.awaiting) begin
               case (b.poll_kind)
                  lsrs_pkg::POLL_SAMPLES: begin
                     st.miss_count    = '0;
                     st.attempt_count = '0;
                     st.armed         = 1'b0;
                     st.reachable     = 1'b0;
                     st.deadline      = '0;
                     st.retry_failed  = 1'b0;
                     if (st.silent_reported) begin
                        st.silent_reported = 1'b0;
                        r.report_running   = 1'b1;
                     end
                     r.forward_samples = 1'b1;
                  end
                  lsrs_pkg::POLL_OTHER_ERR: end_session(st, r, lsrs_pkg::FINISH_ERROR);
                  lsrs_pkg::POLL_CANCELLED: end_session(st, r, lsrs_pkg::FINISH_CANCELLED);
                  lsrs_pkg::POLL_NO_ANSWER: begin
                     // silence only on a real increment that lands on the threshold
                     if (st.miss_count != lsrs_pkg::MISS_COUNT_MAX) begin
                        st.miss_count++;
                        if (st.miss_count == c.miss_threshold) begin
                           st.silent_reported = 1'b1;
                           r.report_silent    = 1'b1;
                           arm_deadline(st, b.now_ms, c.first_retry_delay);
                        end
                     end
                     if (st.armed && st.reachable && b.now_ms >= st.deadline) begin
                        if (c.attempt_limit_on && st.attempt_count >= c.attempt_limit) begin
                           end_session(st, r, lsrs_pkg::FINISH_EXHAUSTED);
                           r.log_retry_failure = st.retry_failed;
                        end else begin
                           st.awaiting       = 1'b1;
                           r.request_restart = 1'b1;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic link_beat_type make_beat(input logic func, input logic [2:0] poll_kind,
                                               input logic [1:0] start_kind,
                                               input logic [63:0] now_ms);
      link_beat_type beat;
      beat.func       = func;
      beat.poll_kind  = poll_kind;
      beat.start_kind = start_kind;
      beat.now_ms     = now_ms;
      return beat;
   endfunction

   // Mostly well-formed traffic that follows the link's state, with noise mixed in
   function automatic link_beat_type random_beat();
      link_beat_type beat;
      int unsigned   roll;
      wall_ms += 64'($urandom_range(0, 25));
      beat.now_ms     = ($urandom_range(0, 19) == 0) ? {$urandom(), $urandom()} : wall_ms;
      beat.start_kind = 2'($urandom_range(0, 3));
      beat.poll_kind  = 3'($urandom_range(0, 7));
      roll = $urandom_range(0, 99);
      if (link_model.awaiting) begin
         // answer the restart request most of the time; polls are dropped here
         beat.func = (roll < 75) ? lsrs_pkg::FUNC_START : lsrs_pkg::FUNC_POLL;
         if (roll < 55) beat.start_kind = lsrs_pkg::START_SUCCESS;
         else if (roll < 75) beat.start_kind = lsrs_pkg::START_BAD_RESP;
      end else begin
         beat.func = (roll < 6) ? lsrs_pkg::FUNC_START : lsrs_pkg::FUNC_POLL;
         roll = $urandom_range(0, 99);
         if (roll < 8) beat.poll_kind = lsrs_pkg::POLL_SAMPLES;
         else if (roll < 18) beat.poll_kind = lsrs_pkg::POLL_EMPTY;
         else if (roll < 80) beat.poll_kind = lsrs_pkg::POLL_NO_ANSWER;
         else if (roll < 90) beat.poll_kind = lsrs_pkg::POLL_BAD_RESP;
      end
      return beat;
   endfunction

   // Draw up to 16 beats until one keeps the session alive, else fall back to an empty poll
   function automatic link_beat_type pick_safe_beat();
      link_beat_type        beat;
      link_state_type       trial;
      lsrs_pkg::result_type outcome;
      for (int tries = 0; tries < 16; tries++) begin
         beat    = random_beat();
         trial   = link_model;
         outcome = supervise(beat, trial, cfg_model);
         if (!outcome.finish) return beat;
      end
      return make_beat(lsrs_pkg::FUNC_POLL, lsrs_pkg::POLL_EMPTY, lsrs_pkg::START_SUCCESS,
                       wall_ms);
   endfunction

   // Offer one beat in bursts with random gaps, then record what it must produce
   task automatic send_beat(input link_beat_type beat);
      int unsigned          gap;
      lsrs_pkg::result_type outcome;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 10);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_func       <= beat.func;
      req_poll_kind  <= beat.poll_kind;
      req_start_kind <= beat.start_kind;
      req_now_ms     <= beat.now_ms;
      do @(posedge clock); while (!req_ready);
      outcome = supervise(beat, link_model, cfg_model);
      expected_outcomes.insert(expected_outcomes.size(), outcome);
      beats_sent++;
      silences_seen += outcome.report_silent;
      restarts_seen += outcome.request_restart;
   endtask

   // Drop valid and wait for every expected result
   task automatic settle();
      req_valid  <= 1'b0;
      burst_left = 0;
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic drive_csr(input logic [lsrs_pkg::CSR_INDEX_WIDTH-1:0] index,
                            input logic [lsrs_pkg::CSR_DATA_WIDTH-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Write all five registers while the block is idle
   task automatic program_cfg(input lsrs_pkg::cfg_type cfg);
      settle();
      drive_csr(lsrs_pkg::CSR_MISS_THRESHOLD,
                lsrs_pkg::CSR_DATA_WIDTH'(cfg.miss_threshold));
      drive_csr(lsrs_pkg::CSR_FIRST_RETRY_DELAY, cfg.first_retry_delay);
      drive_csr(lsrs_pkg::CSR_RETRY_PERIOD, cfg.retry_period);
      drive_csr(lsrs_pkg::CSR_ATTEMPT_LIMIT_ON,
                lsrs_pkg::CSR_DATA_WIDTH'(cfg.attempt_limit_on));
      drive_csr(lsrs_pkg::CSR_ATTEMPT_LIMIT, cfg.attempt_limit);
      csr_we <= 1'b0;
      cfg_model = cfg;
      settings_programmed++;
   endtask

   // ---------------------------------------------------------------- tests

   // While starting, every poll but a cancelled one is ignored; success starts the link
   task automatic test_starting_phase();
      program_cfg('{miss_threshold: 16'd1, first_retry_delay: 32'd0, retry_period: 32'd0,
                    attempt_limit_on: 1'b0, attempt_limit: 32'd0});
      for (int k = 0; k < 8; k++) begin
         if (3'(k) != lsrs_pkg::POLL_CANCELLED)
            send_beat(make_beat(lsrs_pkg::FUNC_POLL, 3'(k), START_UNUSED,
                                (k % 2 != 0) ? TIME_MAX : '0));
      end
      send_beat(make_beat(lsrs_pkg::FUNC_START, lsrs_pkg::POLL_SAMPLES,
                          lsrs_pkg::START_SUCCESS, 64'd0));
   endtask

   // Silence and restart at once, failed and good restarts, recovery, stray starts
   task automatic test_silence_and_restart();
      send_beat(make_beat(lsrs_pkg::FUNC_POLL, lsrs_pkg::POLL_NO_ANSWER,
                          lsrs_pkg::START_SUCCESS, 64'd10));
      send_beat(make_beat(lsrs_pkg::FUNC_POLL, lsrs_pkg::POLL_CANCELLED,
                          lsrs_pkg::START_SUCCESS, 64'd12));
      send_beat(make_beat(lsrs_pkg::FUNC_POLL, lsrs_pkg::POLL_OTHER_ERR,
                          lsrs_pkg::START_SUCCESS, 64'd14));
      send_beat(make_beat(lsrs_pkg::FUNC_START, lsrs_pkg::POLL_SAMPLES,
                          lsrs_pkg::START_BAD_RESP, 64'd20));
      send_beat(make_beat(lsrs_pkg::FUNC_POLL, lsrs_pkg::POLL_NO_ANSWER,
                          lsrs_pkg::START_SUCCESS, 64'd20));
      send_beat(make_beat(lsrs_pkg::FUNC_START, lsrs_pkg::POLL_SAMPLES,
                          lsrs_pkg::START_SUCCESS, 64'd25));
      send_beat(make_beat(lsrs_pkg::FUNC_POLL, lsrs_pkg::POLL_SAMPLES,
                          lsrs_pkg::START_SUCCESS, 64'd30));
      send_beat(make_beat(lsrs_pkg::FUNC_POLL, lsrs_pkg::POLL_EMPTY,
                          lsrs_pkg::START_SUCCESS, 64'd31));
      send_beat(make_beat(lsrs_pkg::FUNC_POLL, lsrs_pkg::POLL_BAD_RESP,
                          lsrs_pkg::START_SUCCESS, 64'd32));
      send_beat(make_beat(lsrs_pkg::FUNC_START, lsrs_pkg::POLL_SAMPLES,
                          START_OTHER_ERR, 64'd33));
      send_beat(make_beat(lsrs_pkg::FUNC_START, lsrs_pkg::POLL_SAMPLES,
                          START_UNUSED, 64'd34));
   endtask

   // Deadlines near the top of time: overflow leaves them dead, an exact fit still fires
   task automatic test_deadline_overflow();
      logic [63:0] fit;
      fit = TIME_MAX - 64'h0000_0000_FFFF_FFFF;
      program_cfg('{miss_threshold: 16'd2, first_retry_delay: '1, retry_period: '1,
                    attempt_limit_on: 1'b1, attempt_limit: '1});
      send_beat(make_beat(lsrs_pkg::FUNC_POLL, lsrs_pkg::POLL_SAMPLES,
                          lsrs_pkg::START_SUCCESS, 64'd0));
      send_beat(make_beat(lsrs_pkg::FUNC_POLL, lsrs_pkg::POLL_NO_ANSWER,
                          lsrs_pkg::START_SUCCESS, TIME_MAX - 64'd5));
      send_beat(make_beat(lsrs_pkg::FUNC_POLL, lsrs_pkg::POLL_NO_ANSWER,
                          lsrs_pkg::START_SUCCESS, TIME_MAX - 64'd5));
      send_beat(make_beat(lsrs_pkg::FUNC_POLL, lsrs_pkg::POLL_NO_ANSWER,
                          lsrs_pkg::START_SUCCESS, TIME_MAX));
      send_beat(make_beat(lsrs_pkg::FUNC_POLL, lsrs_pkg::POLL_SAMPLES,
                          lsrs_pkg::START_SUCCESS, TIME_MAX));
      send_beat(make_beat(lsrs_pkg::FUNC_POLL, lsrs_pkg::POLL_NO_ANSWER,
                          lsrs_pkg::START_SUCCESS, fit));
      send_beat(make_beat(lsrs_pkg::FUNC_POLL, lsrs_pkg::POLL_NO_ANSWER,
                          lsrs_pkg::START_SUCCESS, fit));
      send_beat(make_beat(lsrs_pkg::FUNC_POLL, lsrs_pkg::POLL_NO_ANSWER,
                          lsrs_pkg::START_SUCCESS, TIME_MAX));
      send_beat(make_beat(lsrs_pkg::FUNC_START, lsrs_pkg::POLL_SAMPLES,
                          lsrs_pkg::START_SUCCESS, TIME_MAX));
      send_beat(make_beat(lsrs_pkg::FUNC_POLL, lsrs_pkg::POLL_NO_ANSWER,
                          lsrs_pkg::START_SUCCESS, TIME_MAX));
      send_beat(make_beat(lsrs_pkg::FUNC_POLL, lsrs_pkg::POLL_SAMPLES,
                          lsrs_pkg::START_SUCCESS, TIME_MAX));
   endtask

   // A threshold far above the miss count stays quiet; unused poll codes are dropped
   task automatic test_high_threshold();
      program_cfg('{miss_threshold: lsrs_pkg::MISS_COUNT_MAX, first_retry_delay: 32'd5,
                    retry_period: 32'd7, attempt_limit_on: 1'b0, attempt_limit: 32'd0});
      for (int k = 0; k < 24; k++) begin
         send_beat(make_beat(lsrs_pkg::FUNC_POLL, lsrs_pkg::POLL_NO_ANSWER,
                             lsrs_pkg::START_SUCCESS, 64'(k)));
         if (k % 8 == 0)
            send_beat(make_beat(lsrs_pkg::FUNC_POLL, POLL_UNUSED_LO, START_UNUSED, 64'(k)));
      end
      send_beat(make_beat(lsrs_pkg::FUNC_POLL, POLL_UNUSED_HI, START_UNUSED, 64'd30));
      send_beat(make_beat(lsrs_pkg::FUNC_START, lsrs_pkg::POLL_SAMPLES,
                          lsrs_pkg::START_SUCCESS, 64'd31));
      send_beat(make_beat(lsrs_pkg::FUNC_POLL, lsrs_pkg::POLL_SAMPLES,
                          lsrs_pkg::START_SUCCESS, 64'd32));
   endtask

   // Random sessions under several settings; the second one backs up the result path
   task automatic test_random_traffic();
      lsrs_pkg::cfg_type cfg;
      for (int phase_no = 0; phase_no < 4; phase_no++) begin
         cfg.miss_threshold    = 16'($urandom_range(1, 4));
         cfg.first_retry_delay = $urandom_range(0, 60);
         cfg.retry_period      = $urandom_range(0, 60);
         cfg.attempt_limit_on  = 1'($urandom_range(0, 1));
         cfg.attempt_limit     = $urandom_range(0, 5);
         program_cfg(cfg);
         if (phase_no == 1) hold_off_request = 1'b1;
         repeat (RANDOM_BEATS) send_beat(pick_safe_beat());
      end
   endtask

   // Close the session one way, chosen by the seed, then check it stays closed
   task automatic test_session_end();
      session_end_type   path;
      lsrs_pkg::cfg_type cfg;
      path = session_end_type'($urandom_range(0, 3));
      cfg.miss_threshold    = 16'd1;
      cfg.first_retry_delay = 32'd3;
      cfg.retry_period      = 32'd3;
      cfg.attempt_limit_on  = (path == END_EXHAUSTED);
      cfg.attempt_limit     = $urandom_range(0, 2);
      program_cfg(cfg);
      // leave any pending restart and clear the counters
      if (link_model.awaiting)
         send_beat(make_beat(lsrs_pkg::FUNC_START, lsrs_pkg::POLL_SAMPLES,
                             lsrs_pkg::START_SUCCESS, wall_ms));
      send_beat(make_beat(lsrs_pkg::FUNC_POLL, lsrs_pkg::POLL_SAMPLES,
                          lsrs_pkg::START_SUCCESS, wall_ms));
      case (path)
         END_CANCEL: begin
            session_ending = "a cancelled poll";
            send_beat(make_beat(lsrs_pkg::FUNC_POLL, lsrs_pkg::POLL_CANCELLED,
                                lsrs_pkg::START_SUCCESS, wall_ms));
         end
         END_POLL_ERROR: begin
            session_ending = "a poll error";
            send_beat(make_beat(lsrs_pkg::FUNC_POLL, lsrs_pkg::POLL_OTHER_ERR,
                                lsrs_pkg::START_SUCCESS, wall_ms));
         end
         END_RESTART_ERROR: begin
            session_ending = "a failed restart";
            for (int i = 0; i < 20 && !link_model.awaiting; i++) begin
               wall_ms += 64'd10;
               send_beat(make_beat(lsrs_pkg::FUNC_POLL, lsrs_pkg::POLL_NO_ANSWER,
                                   lsrs_pkg::START_SUCCESS, wall_ms));
            end
            send_beat(make_beat(lsrs_pkg::FUNC_START, lsrs_pkg::POLL_SAMPLES,
                                ($urandom_range(0, 1) != 0) ? START_OTHER_ERR : START_UNUSED,
                                wall_ms));
         end
         default: begin
            session_ending = "exhausted attempts";
            for (int i = 0; i < 40 && link_model.phase != lsrs_pkg::PHASE_FINISHED; i++) begin
               wall_ms += 64'd10;
               if (link_model.awaiting)
                  send_beat(make_beat(lsrs_pkg::FUNC_START, lsrs_pkg::POLL_SAMPLES,
                                      ($urandom_range(0, 1) != 0) ? lsrs_pkg::START_BAD_RESP
                                                                  : lsrs_pkg::START_SUCCESS,
                                      wall_ms));
               else
                  send_beat(make_beat(lsrs_pkg::FUNC_POLL, lsrs_pkg::POLL_NO_ANSWER,
                                      lsrs_pkg::START_SUCCESS, wall_ms));
            end
         end
      endcase
      repeat (12) send_beat(random_beat());
   endtask

   // ---------------------------------------------------------------- result side

   // Stall on a pattern of shifting modes, with one long hold-off on request
   initial begin : result_sink
      sink_mode_type mode;
      int unsigned   mode_left;
      int unsigned   hold_left;
      mode      = SINK_EAGER;
      mode_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_left        = HOLD_OFF_CYCLES;
            hold_off_request = 1'b0;
         end
         if (mode_left == 0) begin
            mode      = sink_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(16, 96);
         end
         mode_left--;
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (mode)
               SINK_EAGER: rsp_ready <= 1'b1;
               SINK_BUSY:  rsp_ready <= ($urandom_range(0, 3) != 0);
               default:    rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   function automatic void check_field(input string name, input logic [1:0] want,
                                       input logic [1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // Compare each result beat with the oldest expectation
   always @(posedge clock) begin
      lsrs_pkg::result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_outcomes.size() == 0) begin
            $error("result beat arrived with no expectation waiting");
            mismatches++;
         end else begin
            want = expected_outcomes.pop_front();
            results_checked++;
            check_field("report_running", want.report_running, rsp_report_running);
            check_field("report_silent", want.report_silent, rsp_report_silent);
            check_field("forward_samples", want.forward_samples, rsp_forward_samples);
            check_field("request_restart", want.request_restart, rsp_request_restart);
            check_field("finish", want.finish, rsp_finish);
            check_field("finish_code", want.finish_code, rsp_finish_code);
            check_field("log_retry_failure", want.log_retry_failure, rsp_log_retry_failure);
         end
      end
   end

   // Give up when neither channel moves for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin : run_tests
      link_model.phase           = lsrs_pkg::PHASE_STARTING;
      link_model.silent_reported = 1'b0;
      link_model.miss_count      = '0;
      link_model.attempt_count   = '0;
      link_model.deadline        = '0;
      link_model.armed           = 1'b0;
      link_model.reachable       = 1'b0;
      link_model.awaiting        = 1'b0;
      link_model.retry_failed    = 1'b0;
      cfg_model = '{miss_threshold: 16'd3, first_retry_delay: 32'd1000,
                    retry_period: 32'd1000, attempt_limit_on: 1'b0, attempt_limit: 32'd0};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_starting_phase();
      test_silence_and_restart();
      test_deadline_overflow();
      test_high_threshold();
      test_random_traffic();
      test_session_end();
      settle();
      $display("Sent %0d beats and checked %0d results under %0d register settings,",
               beats_sent, results_checked, settings_programmed);
      $display("with %0d silence reports and %0d restart requests; session closed by %s.",
               silences_seen, restarts_seen, session_ending);
      if (mismatches == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
